// ===== sv/e8alu_pkg.sv =====
package e8alu_pkg;

  // Operation codes carried by the mode field.
  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBB = 5'd3,
    OP_ANA = 5'd4,
    OP_XRA = 5'd5,
    OP_ORA = 5'd6,
    OP_CMP = 5'd7,
    OP_INR = 5'd8,
    OP_DCR = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RAL = 5'd12,
    OP_RAR = 5'd13,
    OP_DAA = 5'd14,
    OP_CMA = 5'd15,
    OP_STC = 5'd16,
    OP_CMC = 5'd17
  } op_e;

  localparam int unsigned DataW = 8;
  localparam int unsigned ModeW = 5;

  localparam logic [3:0]       DaaNibbleMax = 4'd9;
  localparam logic [DataW-1:0] DaaLowCorr   = 8'h06;
  localparam logic [DataW-1:0] DaaHighCorr  = 8'h60;
  localparam logic [DataW-1:0] DcrAddend    = 8'hFE;
  localparam logic [DataW-1:0] InrAddend    = 8'h01;

  // The flag register.
  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  // Packs the flags as S Z 0 AC 0 P 1 CY.
  function automatic logic [DataW-1:0] pack_status(flags_t f);
    pack_status = {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
  endfunction

endpackage

// ===== sv/eight_bit_alu_with_flags_top.sv =====
// Eight-bit 8085-style ALU with its own flag register. It accepts one item
// per clock cycle while the output side does not stall. Each item passes
// through the input register, then the result register, to the output.
// The rate is set by the flag register, which is read and written in the
// same cycle by the combinational ALU so that each item sees the flags left
// by the one before it. The status word is packed S Z 0 AC 0 P 1 CY; all
// flags are clear after reset.
module eight_bit_alu_with_flags_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [e8alu_pkg::ModeW-1:0] mode_i,
  input  logic [e8alu_pkg::DataW-1:0] left_operand_i,
  input  logic [e8alu_pkg::DataW-1:0] right_operand_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [e8alu_pkg::DataW-1:0] result_o,
  output logic [e8alu_pkg::DataW-1:0] status_word_o,
  output logic                        write_back_o
);

  // Input register.
  logic                        in_valid_q;
  logic [e8alu_pkg::ModeW-1:0] mode_q;
  logic [e8alu_pkg::DataW-1:0] left_q;
  logic [e8alu_pkg::DataW-1:0] right_q;

  // Flag register.
  e8alu_pkg::flags_t flags_q;
  e8alu_pkg::flags_t flags_d;

  // Result register.
  logic                        out_valid_q;
  logic [e8alu_pkg::DataW-1:0] result_q;
  logic [e8alu_pkg::DataW-1:0] result_d;
  logic [e8alu_pkg::DataW-1:0] status_q;
  logic                        write_back_q;
  logic                        write_back_d;

  // Handshake control.
  logic out_ready;
  logic advance;
  logic in_ready;
  logic in_accept;

  assign out_ready  = ~out_valid_q | ~out_stall_i;
  assign advance    = in_valid_q & out_ready;
  assign in_ready   = ~in_valid_q | out_ready;
  assign in_accept  = in_valid_i & in_ready;
  assign in_stall_o = ~in_ready;

  // Capture an item into the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q  <= mode_i;
      left_q  <= left_operand_i;
      right_q <= right_operand_i;
    end
  end

  e8alu_core u_core (
    .mode_i       (mode_q),
    .left_i       (left_q),
    .right_i      (right_q),
    .flags_i      (flags_q),
    .result_o     (result_d),
    .flags_o      (flags_d),
    .write_back_o (write_back_d)
  );

  // Flags update as the item moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (advance) begin
      flags_q <= flags_d;
    end
  end

  // Result register and its valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q     <= result_d;
      status_q     <= e8alu_pkg::pack_status(flags_d);
      write_back_q <= write_back_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_o      = result_q;
  assign status_word_o = status_q;
  assign write_back_o  = write_back_q;

`ifndef NO_ASSERTIONS
  // A full input register facing a stalled result must stall the input side.
  a_stall_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input not stalled while both registers are held");

  // The flags change only when an item moves to the result register.
  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flag register changed without an item");

  // A shown result carries the current flag register.
  a_status_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q == e8alu_pkg::pack_status(flags_q))
    else $error("status word differs from flag register");

  // The fixed bits of the status word.
  a_status_fixed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_word_o[1] && !status_word_o[3] && !status_word_o[5])
    else $error("fixed status bits wrong");
`endif

endmodule

// ===== sv/e8alu_core.sv =====
module e8alu_core (
  input  logic [e8alu_pkg::ModeW-1:0] mode_i,
  input  logic [e8alu_pkg::DataW-1:0] left_i,
  input  logic [e8alu_pkg::DataW-1:0] right_i,
  input  e8alu_pkg::flags_t           flags_i,
  output logic [e8alu_pkg::DataW-1:0] result_o,
  output e8alu_pkg::flags_t           flags_o,
  output logic                        write_back_o
);

  // Shared adder operands for the add, subtract, increment and decrement group.
  logic [e8alu_pkg::DataW-1:0] addend;
  logic                        cin;
  logic                        is_sub;
  logic [e8alu_pkg::DataW:0]   sum;
  logic [4:0]                  half_sum;

  // Decimal adjust terms.
  logic [3:0]                  lo_nib;
  logic [3:0]                  hi_nib;
  logic                        lo_fix;
  logic                        hi_fix;
  logic [e8alu_pkg::DataW-1:0] daa_corr;
  logic [4:0]                  daa_half;

  // Select the second adder input and carry-in for the operation.
  always_comb begin
    addend = right_i;
    cin    = 1'b0;
    is_sub = 1'b0;
    unique case (e8alu_pkg::op_e'(mode_i))
      e8alu_pkg::OP_ADC: begin
        cin = flags_i.cy;
      end
      e8alu_pkg::OP_SUB, e8alu_pkg::OP_CMP: begin
        addend = ~right_i;
        cin    = 1'b1;
        is_sub = 1'b1;
      end
      e8alu_pkg::OP_SBB: begin
        addend = ~right_i;
        cin    = ~flags_i.cy;
        is_sub = 1'b1;
      end
      e8alu_pkg::OP_INR: begin
        addend = e8alu_pkg::InrAddend;
      end
      e8alu_pkg::OP_DCR: begin
        addend = e8alu_pkg::DcrAddend;
        cin    = 1'b1;
      end
      default: begin
        addend = right_i;
      end
    endcase
  end

  assign sum      = {1'b0, left_i} + {1'b0, addend} + {{e8alu_pkg::DataW{1'b0}}, cin};
  assign half_sum = {1'b0, left_i[3:0]} + {1'b0, addend[3:0]} + {4'd0, cin};

  // Decimal adjust: low and high nibble corrections.
  assign lo_nib   = left_i[3:0];
  assign hi_nib   = left_i[7:4];
  assign lo_fix   = (lo_nib > e8alu_pkg::DaaNibbleMax) || flags_i.ac;
  assign hi_fix   = (hi_nib > e8alu_pkg::DaaNibbleMax) || flags_i.cy ||
                    ((hi_nib >= e8alu_pkg::DaaNibbleMax) &&
                     (lo_nib > e8alu_pkg::DaaNibbleMax));
  assign daa_corr = (lo_fix ? e8alu_pkg::DaaLowCorr : '0) |
                    (hi_fix ? e8alu_pkg::DaaHighCorr : '0);
  assign daa_half = {1'b0, lo_nib} + {1'b0, daa_corr[3:0]};

  // Result byte, flag updates and write-back mark.
  always_comb begin
    logic set_szp;
    set_szp      = 1'b0;
    result_o     = left_i;
    flags_o      = flags_i;
    write_back_o = 1'b1;
    unique case (e8alu_pkg::op_e'(mode_i))
      e8alu_pkg::OP_ADD, e8alu_pkg::OP_ADC, e8alu_pkg::OP_SUB,
      e8alu_pkg::OP_SBB, e8alu_pkg::OP_CMP: begin
        result_o   = sum[e8alu_pkg::DataW-1:0];
        flags_o.ac = half_sum[4];
        flags_o.cy = is_sub ? ~sum[e8alu_pkg::DataW] : sum[e8alu_pkg::DataW];
        set_szp    = 1'b1;
        if (e8alu_pkg::op_e'(mode_i) == e8alu_pkg::OP_CMP) begin
          write_back_o = 1'b0;
        end
      end
      e8alu_pkg::OP_INR, e8alu_pkg::OP_DCR: begin
        result_o   = sum[e8alu_pkg::DataW-1:0];
        flags_o.ac = half_sum[4];
        set_szp    = 1'b1;
      end
      e8alu_pkg::OP_ANA: begin
        result_o   = left_i & right_i;
        flags_o.cy = 1'b0;
        flags_o.ac = left_i[3] | right_i[3];
        set_szp    = 1'b1;
      end
      e8alu_pkg::OP_XRA: begin
        result_o   = left_i ^ right_i;
        flags_o.cy = 1'b0;
        flags_o.ac = 1'b0;
        set_szp    = 1'b1;
      end
      e8alu_pkg::OP_ORA: begin
        result_o   = left_i | right_i;
        flags_o.cy = 1'b0;
        flags_o.ac = 1'b0;
        set_szp    = 1'b1;
      end
      e8alu_pkg::OP_RLC: begin
        result_o   = {left_i[6:0], left_i[7]};
        flags_o.cy = left_i[7];
      end
      e8alu_pkg::OP_RRC: begin
        result_o   = {left_i[0], left_i[7:1]};
        flags_o.cy = left_i[0];
      end
      e8alu_pkg::OP_RAL: begin
        result_o   = {left_i[6:0], flags_i.cy};
        flags_o.cy = left_i[7];
      end
      e8alu_pkg::OP_RAR: begin
        result_o   = {flags_i.cy, left_i[7:1]};
        flags_o.cy = left_i[0];
      end
      e8alu_pkg::OP_DAA: begin
        result_o   = left_i + daa_corr;
        flags_o.ac = daa_half[4];
        flags_o.cy = flags_i.cy | hi_fix;
        set_szp    = 1'b1;
      end
      e8alu_pkg::OP_CMA: begin
        result_o = ~left_i;
      end
      e8alu_pkg::OP_STC: begin
        flags_o.cy   = 1'b1;
        write_back_o = 1'b0;
      end
      e8alu_pkg::OP_CMC: begin
        flags_o.cy   = ~flags_i.cy;
        write_back_o = 1'b0;
      end
      default: begin
        // Unused codes leave the flags alone and store nothing.
        write_back_o = 1'b0;
      end
    endcase
    if (set_szp) begin
      flags_o.s = result_o[e8alu_pkg::DataW-1];
      flags_o.z = (result_o == '0);
      flags_o.p = ~^result_o;
    end
  end

endmodule

// ===== dv/tb_eight_bit_alu_with_flags_top.sv =====
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_flags_top;

  localparam int RandomItems = 550;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;
  localparam logic [e8alu_pkg::ModeW-1:0] FirstUnusedMode =
    e8alu_pkg::ModeW'(e8alu_pkg::OP_CMC) + 1'b1;
  localparam logic [e8alu_pkg::ModeW-1:0] LastUnusedMode = '1;

  // One expected result item.
  typedef struct packed {
    logic [e8alu_pkg::DataW-1:0] result;
    logic [e8alu_pkg::DataW-1:0] status_word;
    logic                        write_back;
  } alu_outcome_t;

  // Keeps a private copy of the flag register, works out what each accepted
  // operation must return, and checks the returned items in order.
  class alu_flag_board;
    e8alu_pkg::flags_t flags;
    alu_outcome_t      pending_results[$];
    int                mismatches;

    function new();
      flags = '0;
      mismatches = 0;
    endfunction

    function void set_szp(logic [e8alu_pkg::DataW-1:0] v);
      flags.s = v[7];
      flags.z = (v == '0);
      flags.p = ~^v;
    endfunction

    // Eight-bit add with carry-in; sets CY and AC from the carries, S Z P from the sum.
    function logic [e8alu_pkg::DataW-1:0] add_bytes(logic [e8alu_pkg::DataW-1:0] a,
                                                    logic [e8alu_pkg::DataW-1:0] b,
                                                    logic cin);
      logic [e8alu_pkg::DataW:0] sum;
      logic [4:0]                low_sum;
      sum = {1'b0, a} + {1'b0, b} + {{e8alu_pkg::DataW{1'b0}}, cin};
      low_sum = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
      flags.ac = low_sum[4];
      flags.cy = sum[e8alu_pkg::DataW];
      set_szp(sum[e8alu_pkg::DataW-1:0]);
      return sum[e8alu_pkg::DataW-1:0];
    endfunction

    // Subtract as a + ~b + !borrow; CY ends up as the borrow.
    function logic [e8alu_pkg::DataW-1:0] sub_bytes(logic [e8alu_pkg::DataW-1:0] a,
                                                    logic [e8alu_pkg::DataW-1:0] b,
                                                    logic borrow);
      logic [e8alu_pkg::DataW:0]   sum;
      logic [4:0]                  low_sum;
      logic [e8alu_pkg::DataW-1:0] nb;
      nb = ~b;
      sum = {1'b0, a} + {1'b0, nb} + {{e8alu_pkg::DataW{1'b0}}, ~borrow};
      low_sum = {1'b0, a[3:0]} + {1'b0, nb[3:0]} + {4'd0, ~borrow};
      flags.ac = low_sum[4];
      flags.cy = ~sum[e8alu_pkg::DataW];
      set_szp(sum[e8alu_pkg::DataW-1:0]);
      return sum[e8alu_pkg::DataW-1:0];
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(logic [e8alu_pkg::ModeW-1:0] mode,
                            logic [e8alu_pkg::DataW-1:0] a,
                            logic [e8alu_pkg::DataW-1:0] b);
      alu_outcome_t                want;
      logic [e8alu_pkg::DataW-1:0] r;
      logic [e8alu_pkg::DataW-1:0] corr;
      logic [4:0]                  low_sum;
      logic                        wb;
      logic                        cy;
      r = a;
      wb = 1'b1;
      case (mode)
        e8alu_pkg::OP_ADD: r = add_bytes(a, b, 1'b0);
        e8alu_pkg::OP_ADC: r = add_bytes(a, b, flags.cy);
        e8alu_pkg::OP_SUB: r = sub_bytes(a, b, 1'b0);
        e8alu_pkg::OP_SBB: r = sub_bytes(a, b, flags.cy);
        e8alu_pkg::OP_ANA: begin
          r = a & b;
          flags.cy = 1'b0;
          flags.ac = a[3] | b[3];
          set_szp(r);
        end
        e8alu_pkg::OP_XRA: begin
          r = a ^ b;
          flags.cy = 1'b0;
          flags.ac = 1'b0;
          set_szp(r);
        end
        e8alu_pkg::OP_ORA: begin
          r = a | b;
          flags.cy = 1'b0;
          flags.ac = 1'b0;
          set_szp(r);
        end
        e8alu_pkg::OP_CMP: begin
          r = sub_bytes(a, b, 1'b0);
          wb = 1'b0;
        end
        e8alu_pkg::OP_INR: begin
          cy = flags.cy;
          r = add_bytes(a, 8'h01, 1'b0);
          flags.cy = cy;
        end
        e8alu_pkg::OP_DCR: begin
          cy = flags.cy;
          r = sub_bytes(a, 8'h01, 1'b0);
          flags.cy = cy;
        end
        e8alu_pkg::OP_RLC: begin
          flags.cy = a[7];
          r = {a[6:0], a[7]};
        end
        e8alu_pkg::OP_RRC: begin
          flags.cy = a[0];
          r = {a[0], a[7:1]};
        end
        e8alu_pkg::OP_RAL: begin
          r = {a[6:0], flags.cy};
          flags.cy = a[7];
        end
        e8alu_pkg::OP_RAR: begin
          r = {flags.cy, a[7:1]};
          flags.cy = a[0];
        end
        e8alu_pkg::OP_DAA: begin
          // Decimal adjust: low correction on a low digit above nine or AC,
          // high correction on a high digit above nine, CY, or a nine that
          // the low correction will push over.
          corr = '0;
          cy = flags.cy;
          if (a[3:0] > 4'd9 || flags.ac) corr |= 8'h06;
          if (a[7:4] > 4'd9 || cy || (a[7:4] >= 4'd9 && a[3:0] > 4'd9)) begin
            corr |= 8'h60;
            cy = 1'b1;
          end
          low_sum = {1'b0, a[3:0]} + {1'b0, corr[3:0]};
          flags.ac = low_sum[4];
          r = a + corr;
          flags.cy = cy;
          set_szp(r);
        end
        e8alu_pkg::OP_CMA: r = ~a;
        e8alu_pkg::OP_STC: begin
          flags.cy = 1'b1;
          wb = 1'b0;
        end
        e8alu_pkg::OP_CMC: begin
          flags.cy = ~flags.cy;
          wb = 1'b0;
        end
        default: wb = 1'b0;
      endcase
      want.result = r;
      want.status_word = {flags.s, flags.z, 1'b0, flags.ac, 1'b0, flags.p, 1'b1, flags.cy};
      want.write_back = wb;
      pending_results = {pending_results, want};
    endfunction

    // Compares one returned item with the oldest expectation.
    function void check_result(logic [e8alu_pkg::DataW-1:0] r,
                               logic [e8alu_pkg::DataW-1:0] st, logic wb);
      alu_outcome_t want;
      if (pending_results.size() == 0) begin
        $error("result item with none expected: result %02h status_word %02h", r, st);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (r !== want.result) begin
        $error("result: expected %02h, actual %02h", want.result, r);
        mismatches++;
      end
      if (st !== want.status_word) begin
        $error("status_word: expected %02h, actual %02h", want.status_word, st);
        mismatches++;
      end
      if (wb !== want.write_back) begin
        $error("write_back: expected %0b, actual %0b", want.write_back, wb);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [e8alu_pkg::ModeW-1:0] mode = '0;
  logic [e8alu_pkg::DataW-1:0] left_operand = '0;
  logic [e8alu_pkg::DataW-1:0] right_operand = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [e8alu_pkg::DataW-1:0] result;
  logic [e8alu_pkg::DataW-1:0] status_word;
  logic                        write_back;

  alu_flag_board board = new();
  int            stall_left = 0;
  logic [e8alu_pkg::DataW-1:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0,
                                                    8'h80, 8'h7F, 8'h99, 8'h09};

  eight_bit_alu_with_flags_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .mode_i         (mode),
    .left_operand_i (left_operand),
    .right_operand_i(right_operand),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_o       (result),
    .status_word_o  (status_word),
    .write_back_o   (write_back)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watch both channels; an item accepted on either side goes to the board.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_item(mode, left_operand, right_operand);
      if (out_valid && !out_stall) board.check_result(result, status_word, write_back);
    end
  end

  // Output stall in runs: free stretches, short stalls and a few long ones.
  always @(negedge clk) begin : stall_gen
    int roll;
    if (stall_left == 0) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        out_stall <= 1'b0;
        stall_left = $urandom_range(30, 1);
      end else if (roll < 92) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(3, 1);
      end else begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(40, 8);
      end
    end else begin
      stall_left--;
    end
  end

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 6);
  endfunction

  function automatic logic [e8alu_pkg::DataW-1:0] pick_operand();
    if ($urandom_range(99) < 25) return corner_bytes[$urandom_range(7)];
    return e8alu_pkg::DataW'($urandom);
  endfunction

  function automatic logic [e8alu_pkg::DataW-1:0] pick_bcd();
    return {4'($urandom_range(9)), 4'($urandom_range(9))};
  endfunction

  // Offers one item after the given number of idle cycles and waits until
  // it is taken. Valid stays high into the next item when there is no gap.
  task automatic send_item(input logic [e8alu_pkg::ModeW-1:0] m,
                           input logic [e8alu_pkg::DataW-1:0] a,
                           input logic [e8alu_pkg::DataW-1:0] b, input int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    left_operand <= a;
    right_operand <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [e8alu_pkg::DataW-1:0] a;
    logic [e8alu_pkg::DataW-1:0] b;
    logic [e8alu_pkg::ModeW-1:0] m;
    int                          gap;
    int                          n;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: carries, borrows, zero and sign, every operation, the
    // decimal adjust corrections and codes with no operation behind them.
    send_item(e8alu_pkg::OP_ADD, 8'hFF, 8'h01, 0);
    send_item(e8alu_pkg::OP_ADC, 8'h00, 8'h00, 0);
    send_item(e8alu_pkg::OP_ADD, 8'h7F, 8'h01, 1);
    send_item(e8alu_pkg::OP_SUB, 8'h00, 8'h01, 0);
    send_item(e8alu_pkg::OP_SBB, 8'h05, 8'h05, 0);
    send_item(e8alu_pkg::OP_SUB, 8'h42, 8'h42, 0);
    send_item(e8alu_pkg::OP_ANA, 8'hF0, 8'h08, 0);
    send_item(e8alu_pkg::OP_ANA, 8'h0F, 8'hF0, 2);
    send_item(e8alu_pkg::OP_XRA, 8'hFF, 8'hFF, 0);
    send_item(e8alu_pkg::OP_ORA, 8'h55, 8'hAA, 0);
    send_item(e8alu_pkg::OP_CMP, 8'h10, 8'h20, 0);
    send_item(e8alu_pkg::OP_INR, 8'hFF, 8'h00, 0);
    send_item(e8alu_pkg::OP_DCR, 8'h00, 8'hFF, 0);
    send_item(e8alu_pkg::OP_STC, 8'h3C, 8'h00, 0);
    send_item(e8alu_pkg::OP_RLC, 8'h80, 8'h00, 0);
    send_item(e8alu_pkg::OP_RRC, 8'h01, 8'h00, 0);
    send_item(e8alu_pkg::OP_RAL, 8'h80, 8'h00, 0);
    send_item(e8alu_pkg::OP_RAR, 8'h01, 8'h00, 0);
    send_item(e8alu_pkg::OP_ADD, 8'h99, 8'h01, 0);
    send_item(e8alu_pkg::OP_DAA, 8'h9A, 8'h00, 0);
    send_item(e8alu_pkg::OP_ADD, 8'h08, 8'h08, 0);
    send_item(e8alu_pkg::OP_DAA, 8'h10, 8'h00, 0);
    send_item(e8alu_pkg::OP_DAA, 8'hA0, 8'h00, 0);
    send_item(e8alu_pkg::OP_CMA, 8'h5A, 8'h00, 0);
    send_item(e8alu_pkg::OP_CMC, 8'hC3, 8'h00, 0);
    send_item(FirstUnusedMode, 8'hA5, 8'h5A, 0);
    send_item(LastUnusedMode, 8'hFF, 8'hFF, 0);

    // Random: plain operations, BCD additions followed by an adjust, and a
    // few unused codes. Every fourth stretch runs with no sender gaps.
    n = 0;
    while (n < RandomItems) begin
      gap = (n % 64 < 16) ? 0 : pick_gap();
      if (n == RandomItems / 2) wait_for_drain();
      if ($urandom_range(99) < 20) begin
        a = pick_bcd();
        b = pick_bcd();
        send_item(($urandom_range(1) != 0) ? e8alu_pkg::OP_ADD : e8alu_pkg::OP_ADC,
                  a, b, gap);
        send_item(e8alu_pkg::OP_DAA, a + b, e8alu_pkg::DataW'($urandom),
                  (n % 64 < 16) ? 0 : pick_gap());
        n += 2;
      end else begin
        if ($urandom_range(99) < 6) begin
          m = e8alu_pkg::ModeW'($urandom_range(LastUnusedMode, FirstUnusedMode));
        end else begin
          m = e8alu_pkg::ModeW'($urandom_range(e8alu_pkg::OP_CMC, e8alu_pkg::OP_ADD));
        end
        send_item(m, pick_operand(), pick_operand(), gap);
        n++;
      end
    end

    wait_for_drain();
    repeat (DrainCycles) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
